// ===== design/sio_pkg.sv =====
`default_nettype none

package sio_pkg;

   // Field widths of the bus access and of the result
   localparam int ADDR_W       = 10;
   localparam int BYTE_W       = 8;
   localparam int STRAP_W      = 16;
   localparam int IRQ_W        = 4;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 72;

   // Port windows
   localparam logic [ADDR_W-1:0] PORT_LOW_KEY   = 10'h250;
   localparam logic [ADDR_W-1:0] PORT_LOW_INDEX = 10'h251;
   localparam logic [ADDR_W-1:0] PORT_LOW_DATA  = 10'h252;
   localparam logic [ADDR_W-1:0] PORT_HIGH_KEY  = 10'h3f0;
   localparam logic [ADDR_W-1:0] PORT_HIGH_DATA = 10'h3f1;

   // Unlock keys and the relock byte
   localparam logic [BYTE_W-1:0] KEY_LOW    = 8'h88;
   localparam logic [BYTE_W-1:0] KEY_HIGH   = 8'h86;
   localparam logic [BYTE_W-1:0] KEY_RELOCK = 8'haa;
   localparam logic [BYTE_W-1:0] BYTE_IDLE  = 8'hff;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   // Registers held at fixed places, among them those that the resource decode reads
   typedef struct packed {
      logic [7:0] r00;
      logic [7:0] r03;
      logic [7:0] r04;
      logic [7:0] r06;
      logic [7:0] r07;
      logic [7:0] r09;
      logic [7:0] r0a;
      logic [7:0] r0c;
      logic [7:0] r0d;
      logic [7:0] r16;
      logic [7:0] r19;
      logic [7:0] r1e;
      logic [7:0] r20;
      logic [7:0] r21;
      logic [7:0] r22;
      logic [7:0] r23;
      logic [7:0] r24;
      logic [7:0] r25;
      logic [7:0] r26;
      logic [7:0] r27;
      logic [7:0] r28;
      logic [7:0] r29;
   } shadow_type;

   // Decoded resources, highest field first so packing puts floppy_base lowest
   typedef struct packed {
      logic [IRQ_W-1:0]  uart_b_irq;
      logic [ADDR_W-1:0] uart_b_base;
      logic [1:0]        uart_a_clock;
      logic [IRQ_W-1:0]  uart_a_irq;
      logic [ADDR_W-1:0] uart_a_base;
      logic [1:0]        printer_mode;
      logic [IRQ_W-1:0]  printer_irq;
      logic [ADDR_W-1:0] printer_base;
      logic [IRQ_W-1:0]  floppy_irq;
      logic [ADDR_W-1:0] floppy_base;
   } resource_type;

   typedef struct packed {
      resource_type      res;
      logic              unlocked;
      logic [BYTE_W-1:0] read_data;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/sio_ctrl.sv =====
`default_nettype none

module sio_ctrl
   import sio_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not enter execute");

   a_exec_to_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_LOAD))
      else $error("execute not followed by load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && rsp_tvalid && !rsp_tready) |=> (state_ff == ST_LOAD))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== design/sio_decode.sv =====
`default_nettype none

module sio_decode
   import sio_pkg::*;
(
   input  wire shadow_type regs,
   output resource_type    res
);

   function automatic logic [IRQ_W-1:0] irq_map(logic [3:0] sel);
      logic [IRQ_W-1:0] irq;
      case (sel)
         4'd1:    irq = 4'd5;
         4'd2:    irq = 4'd2;
         4'd3:    irq = 4'd3;
         4'd4:    irq = 4'd4;
         4'd5:    irq = 4'd7;
         4'd6:    irq = 4'd6;
         4'd7:    irq = 4'd9;
         4'd8:    irq = 4'd10;
         default: irq = 4'd0;
      endcase
      return irq;
   endfunction

   logic epp_ok;
   logic uart_a_en;
   logic uart_b_en;

   // Enabled bases always land inside 0x100..0x3ff, so no fallback applies
   always_comb begin
      epp_ok    = regs.r09[7] & regs.r00[2];
      uart_a_en = !regs.r04[5] && (regs.r24[7:6] != 2'b00);
      uart_b_en = !regs.r04[4] && (regs.r25[7:6] != 2'b00);

      res.floppy_base = (!regs.r06[3] && (regs.r20[7:6] != 2'b00)) ?
                        {regs.r20[7:2], 4'b0000} : '0;
      res.floppy_irq  = irq_map(regs.r29[7:4]);

      res.printer_base = (!regs.r04[7] && (regs.r23[7:6] != 2'b00)) ?
                         {regs.r23[7:1], regs.r23[0] & ~epp_ok, 2'b00} : '0;
      res.printer_irq  = irq_map(regs.r27[3:0]);
      res.printer_mode = {regs.r09[7] & regs.r00[3], epp_ok};

      res.uart_a_base  = uart_a_en ? {regs.r24[7:1], 3'b000} : '0;
      res.uart_a_irq   = uart_a_en ? irq_map(regs.r28[7:4]) : '0;
      res.uart_a_clock = regs.r19[1] ? 2'd2 : (regs.r03[1] ? 2'd1 : 2'd0);

      res.uart_b_base  = uart_b_en ? {regs.r25[7:1], 3'b000} : '0;
      res.uart_b_irq   = uart_b_en ? irq_map(regs.r28[3:0]) : '0;
   end

endmodule

`default_nettype wire

// ===== design/sio_dp.sv =====
`default_nettype none

module sio_dp
   import sio_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   input  wire logic [STRAP_W-1:0] csr_data,
   input  wire cmd_type            cmd,
   input  wire logic               req_opcode,
   input  wire logic [ADDR_W-1:0]  req_address,
   input  wire logic [BYTE_W-1:0]  req_write_data,
   output result_type              result
);

   localparam int DEPTH = 1 << BYTE_W;

   localparam logic [7:0] REG_00 = 8'h00;
   localparam logic [7:0] REG_03 = 8'h03;
   localparam logic [7:0] REG_04 = 8'h04;
   localparam logic [7:0] REG_06 = 8'h06;
   localparam logic [7:0] REG_07 = 8'h07;
   localparam logic [7:0] REG_09 = 8'h09;
   localparam logic [7:0] REG_0A = 8'h0a;
   localparam logic [7:0] REG_0C = 8'h0c;
   localparam logic [7:0] REG_0D = 8'h0d;
   localparam logic [7:0] REG_16 = 8'h16;
   localparam logic [7:0] REG_19 = 8'h19;
   localparam logic [7:0] REG_1E = 8'h1e;
   localparam logic [7:0] REG_20 = 8'h20;
   localparam logic [7:0] REG_21 = 8'h21;
   localparam logic [7:0] REG_22 = 8'h22;
   localparam logic [7:0] REG_23 = 8'h23;
   localparam logic [7:0] REG_24 = 8'h24;
   localparam logic [7:0] REG_25 = 8'h25;
   localparam logic [7:0] REG_26 = 8'h26;
   localparam logic [7:0] REG_27 = 8'h27;
   localparam logic [7:0] REG_28 = 8'h28;
   localparam logic [7:0] REG_29 = 8'h29;
   localparam logic [7:0] PROTECT_END = 8'h18;

   function automatic shadow_type shadow_group(shadow_type s, logic on);
      shadow_type t;
      t     = s;
      t.r1e = on ? 8'h81 : 8'h00;
      t.r20 = on ? 8'hfc : 8'h00;
      t.r21 = on ? 8'h7c : 8'h00;
      t.r22 = on ? 8'hfd : 8'h00;
      t.r23 = on ? 8'hde : 8'h00;
      t.r24 = on ? 8'hfe : 8'h00;
      t.r25 = on ? 8'hbe : 8'h00;
      t.r26 = on ? 8'h23 : 8'h00;
      t.r27 = on ? 8'h65 : 8'h00;
      t.r28 = on ? 8'h43 : 8'h00;
      t.r29 = on ? 8'h62 : 8'h00;
      return t;
   endfunction

   function automatic shadow_type shadow_reset(logic [STRAP_W-1:0] strap);
      shadow_type t;
      t     = '0;
      t.r03 = 8'h30;
      t.r07 = 8'hf5;
      t.r09 = strap[15:8];
      t.r0a = 8'h1f;
      t.r0c = 8'h28;
      t.r0d = 8'ha3;
      t.r16 = strap[7:0] | 8'h02;
      return shadow_group(t, 1'b1);
   endfunction

   function automatic logic shadow_hit(logic [7:0] idx);
      logic hit;
      case (idx)
         REG_00, REG_03, REG_04, REG_06, REG_07, REG_09, REG_0A, REG_0C, REG_0D,
         REG_16, REG_19, REG_1E, REG_20, REG_21, REG_22, REG_23, REG_24, REG_25,
         REG_26, REG_27, REG_28, REG_29: hit = 1'b1;
         default:                        hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic [7:0] shadow_read(shadow_type s, logic [7:0] idx);
      logic [7:0] v;
      case (idx)
         REG_00:  v = s.r00;
         REG_03:  v = s.r03;
         REG_04:  v = s.r04;
         REG_06:  v = s.r06;
         REG_07:  v = s.r07;
         REG_09:  v = s.r09;
         REG_0A:  v = s.r0a;
         REG_0C:  v = s.r0c;
         REG_0D:  v = s.r0d;
         REG_16:  v = s.r16;
         REG_19:  v = s.r19;
         REG_1E:  v = s.r1e;
         REG_20:  v = s.r20;
         REG_21:  v = s.r21;
         REG_22:  v = s.r22;
         REG_23:  v = s.r23;
         REG_24:  v = s.r24;
         REG_25:  v = s.r25;
         REG_26:  v = s.r26;
         REG_27:  v = s.r27;
         REG_28:  v = s.r28;
         REG_29:  v = s.r29;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic shadow_type shadow_write(shadow_type s, logic [7:0] idx,
                                               logic [7:0] v);
      shadow_type t;
      t = s;
      case (idx)
         REG_00:  t.r00 = v;
         REG_03:  t.r03 = v;
         REG_04:  t.r04 = v;
         REG_06:  t.r06 = v;
         REG_07:  t.r07 = v;
         REG_09:  t.r09 = v;
         REG_0A:  t.r0a = v;
         REG_0C:  t.r0c = v;
         REG_0D:  t.r0d = v;
         REG_16:  t.r16 = v;
         REG_19:  t.r19 = v;
         REG_1E:  t.r1e = v;
         REG_20:  t.r20 = v;
         REG_21:  t.r21 = v;
         REG_22:  t.r22 = v;
         REG_23:  t.r23 = v;
         REG_24:  t.r24 = v;
         REG_25:  t.r25 = v;
         REG_26:  t.r26 = v;
         REG_27:  t.r27 = v;
         REG_28:  t.r28 = v;
         REG_29:  t.r29 = v;
         default: t = s;
      endcase
      return t;
   endfunction

   // captured beat
   logic              op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [BYTE_W-1:0] wdata_ff;

   // configuration state
   shadow_type        shadow_ff, shadow_in;
   logic              mode_ff, mode_in;
   logic              first_ff, first_in;
   logic [BYTE_W-1:0] index_ff, index_in;
   logic              wp_ff, wp_in;
   logic [BYTE_W-1:0] rd_ff, rd_in;

   // register file for the indexes without a shadow copy
   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] mem_rd_ff;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic              rd_valid_ff;
   logic              mem_we;

   result_type        result_ff;
   resource_type      res;

   logic              hi;
   logic [BYTE_W-1:0] key;
   logic              is_key;
   logic              is_index;
   logic              is_data;
   logic              hit;
   logic [BYTE_W-1:0] cur;
   logic [BYTE_W-1:0] diff;

   always_comb begin
      hi       = shadow_ff.r16[0];
      key      = (hi ? KEY_HIGH : KEY_LOW) | {7'b0, shadow_ff.r0c[5]};
      is_key   = hi ? (addr_ff == PORT_HIGH_KEY)  : (addr_ff == PORT_LOW_KEY);
      is_index = hi ? (addr_ff == PORT_HIGH_KEY)  : (addr_ff == PORT_LOW_INDEX);
      is_data  = hi ? (addr_ff == PORT_HIGH_DATA) : (addr_ff == PORT_LOW_DATA);
      hit      = shadow_hit(index_ff);
      cur      = hit ? shadow_read(shadow_ff, index_ff) :
                 (rd_valid_ff ? mem_rd_ff : 8'h00);
      diff     = wdata_ff ^ cur;
   end

   always_comb begin
      shadow_in = shadow_ff;
      mode_in   = mode_ff;
      first_in  = first_ff;
      index_in  = index_ff;
      wp_in     = wp_ff;
      rd_in     = rd_ff;
      mem_we    = 1'b0;
      if (cmd.execute) begin
         rd_in = BYTE_IDLE;
         if (op_ff == OP_WRITE) begin
            if (!hi && is_key) begin
               mode_in = (wdata_ff == key);
            end else if (!hi && is_index) begin
               index_in = wdata_ff;
            end else if (hi && is_key) begin
               if (wdata_ff == key && !mode_ff) begin
                  mode_in  = first_ff;
                  first_in = !first_ff;
               end else if (mode_ff) begin
                  index_in = wdata_ff;
                  if (wdata_ff == KEY_RELOCK) begin
                     mode_in = 1'b0;
                  end
               end else begin
                  first_in = 1'b0;
               end
            end else if (is_data && mode_ff && !wp_ff) begin
               mem_we    = !hit;
               shadow_in = shadow_write(shadow_ff, index_ff, wdata_ff);
               if (index_ff == REG_09 && diff[6]) begin
                  wp_in = wdata_ff[6];
               end else if (index_ff == REG_16 && diff[1]) begin
                  shadow_in = shadow_group(shadow_in, wdata_ff[1]);
               end else if (index_ff == REG_28) begin
                  // a nibble written to zero falls back to its fixed IRQ select
                  if (diff[3:0] != 4'h0 && wdata_ff[3:0] == 4'h0) begin
                     shadow_in.r28[1:0] = 2'b11;
                  end
                  if (diff[7:4] != 4'h0 && wdata_ff[7:4] == 4'h0) begin
                     shadow_in.r28[6] = 1'b1;
                  end
               end
            end
         end else if (mode_ff) begin
            if (is_index) begin
               rd_in = index_ff;
            end else if (is_data && (index_ff == REG_07 || index_ff >= PROTECT_END ||
                                     !wp_ff)) begin
               rd_in = cur;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (mem_we) begin
         valid_in[index_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_ff <= shadow_reset('0);
         mode_ff   <= 1'b0;
         first_ff  <= 1'b0;
         index_ff  <= '0;
         wp_ff     <= 1'b0;
         valid_ff  <= '0;
      end else if (csr_valid) begin
         shadow_ff <= shadow_reset(csr_data);
         mode_ff   <= 1'b0;
         first_ff  <= 1'b0;
         index_ff  <= '0;
         wp_ff     <= 1'b0;
         valid_ff  <= '0;
      end else begin
         shadow_ff <= shadow_in;
         mode_ff   <= mode_in;
         first_ff  <= first_in;
         index_ff  <= index_in;
         wp_ff     <= wp_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[index_ff] <= wdata_ff;
      end
      mem_rd_ff   <= mem[index_ff];
      rd_valid_ff <= valid_ff[index_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
      rd_ff <= rd_in;
      if (cmd.load) begin
         result_ff <= '{res: res, unlocked: mode_ff, read_data: rd_ff};
      end
   end

   sio_decode u_decode (
      .regs (shadow_ff),
      .res  (res)
   );

   assign result = result_ff;

   a_protect_sticky: assert property (@(posedge clock) disable iff (reset)
      (wp_ff && !csr_valid) |=> wp_ff)
      else $error("write protect cleared without a reset");

endmodule

`default_nettype wire

// ===== design/superio_config_port_decoder_top.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser opcode, tdata address + write byte
// rsp       out        rsp_tvalid/rsp_tready  tdata read byte, lock flag, resources
// csr       in         csr_valid/csr_ready    16-bit power-on strap
//
// Each access passes through accept, execute against the register file, and
// load of the output register. The next beat is taken in the cycle after the load.
// The execute cycle reads the register file through its registered read port,
// which is addressed by the index pointer ahead of the beat.
// Reset, and any strap write, restore the register defaults; the
// register file's valid bits clear at once, so no clearing pass follows.
// A result held by a stalled rsp side blocks the load of the next one, and no beat after that is taken until it loads.

module superio_config_port_decoder_top
   import sio_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // bits from lowest: io_address[9:0], write_data[17:10], zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // bits from lowest: opcode[0]
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // bits from lowest: read_data[7:0], unlocked[8], floppy_base[18:9],
   // floppy_irq[22:19], printer_base[32:23], printer_irq[36:33],
   // printer_mode[38:37], uart_a_base[48:39], uart_a_irq[52:49],
   // uart_a_clock[54:53], uart_b_base[64:55], uart_b_irq[68:65], zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [STRAP_W-1:0]     csr_data
);

   cmd_type    cmd;
   result_type result;

   // strap writes must arrive only while idle (the block does not enforce it); take them whenever out of reset
   assign csr_ready = !reset;

   sio_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sio_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .req_opcode     (req_tuser),
      .req_address    (req_tdata[ADDR_W-1:0]),
      .req_write_data (req_tdata[ADDR_W+BYTE_W-1:ADDR_W]),
      .result         (result)
   );

   // pad the result up to whole bytes
   assign rsp_tdata = {{(RSP_TDATA_W-RESULT_W){1'b0}}, result};

endmodule

`default_nettype wire

// ===== tb/superio_config_port_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module superio_config_port_decoder_top_tb;
   import sio_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;

   // Register indexes that the decode and the stimulus touch by name
   localparam logic [7:0] REG_LPT_MODE    = 8'h00;
   localparam logic [7:0] REG_UART_CLK    = 8'h03;
   localparam logic [7:0] REG_DISABLE     = 8'h04;
   localparam logic [7:0] REG_FDC_CTRL    = 8'h06;
   localparam logic [7:0] REG_DRIVE_TYPE  = 8'h07;
   localparam logic [7:0] REG_STRAP_HI    = 8'h09;
   localparam logic [7:0] REG_MISC_0A     = 8'h0a;
   localparam logic [7:0] REG_KEY_CTRL    = 8'h0c;
   localparam logic [7:0] REG_MISC_0D     = 8'h0d;
   localparam logic [7:0] REG_STRAP_LO    = 8'h16;
   localparam logic [7:0] REG_PROTECT_END = 8'h18;
   localparam logic [7:0] REG_COM_CLK     = 8'h19;
   localparam logic [7:0] REG_GROUP_FIRST = 8'h1e;
   localparam logic [7:0] REG_FDC_BASE    = 8'h20;
   localparam logic [7:0] REG_LPT_BASE    = 8'h23;
   localparam logic [7:0] REG_COMA_BASE   = 8'h24;
   localparam logic [7:0] REG_COMB_BASE   = 8'h25;
   localparam logic [7:0] REG_LPT_IRQ     = 8'h27;
   localparam logic [7:0] REG_COM_IRQ     = 8'h28;
   localparam logic [7:0] REG_FDC_IRQ     = 8'h29;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [STRAP_W-1:0]     csr_data   = '0;

   superio_config_port_decoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Shadow copy of the configuration space, advanced once per accepted access beat
   logic [7:0] shadow_regs [0:255];
   logic [7:0] index_reg;
   bit         in_config;
   bit         key_armed;
   bit         protect_set;

   result_type pending_results [$];
   result_type seen_result;
   result_type want_result;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int stall_left     = 0;
   int next_gap       = 0;
   bit req_held       = 1'b0;
   bit no_gaps        = 1'b0;

   // ---------------------------------------------------------------- shadow model

   function automatic logic [7:0] resource_default(input int slot);
      case (slot)
         0:       return 8'h81;
         2:       return 8'hfc;
         3:       return 8'h7c;
         4:       return 8'hfd;
         5:       return 8'hde;
         6:       return 8'hfe;
         7:       return 8'hbe;
         8:       return 8'h23;
         9:       return 8'h65;
         10:      return 8'h43;
         11:      return 8'h62;
         default: return 8'h00;
      endcase
   endfunction

   // Reload or clear the resource group; the byte right after its head is not part of it
   function automatic void reload_resources(input bit on);
      int i;
      for (i = 0; i < 12; i++)
         if (i != 1) shadow_regs[REG_GROUP_FIRST + i] = on ? resource_default(i) : 8'h00;
   endfunction

   function automatic void reset_shadow(input logic [STRAP_W-1:0] strap);
      int i;
      for (i = 0; i < 256; i++) shadow_regs[i] = 8'h00;
      shadow_regs[REG_UART_CLK]   = 8'h30;
      shadow_regs[REG_DRIVE_TYPE] = 8'hf5;
      shadow_regs[REG_STRAP_HI]   = strap[15:8];
      shadow_regs[REG_MISC_0A]    = 8'h1f;
      shadow_regs[REG_KEY_CTRL]   = 8'h28;
      shadow_regs[REG_MISC_0D]    = 8'ha3;
      shadow_regs[REG_STRAP_LO]   = strap[7:0] | 8'h02;
      reload_resources(1'b1);
      in_config   = 1'b0;
      key_armed   = 1'b0;
      index_reg   = 8'h00;
      protect_set = 1'b0;
   endfunction

   function automatic bit window_high();
      return shadow_regs[REG_STRAP_LO][0];
   endfunction

   function automatic logic [7:0] unlock_byte();
      return (window_high() ? KEY_HIGH : KEY_LOW) | {7'd0, shadow_regs[REG_KEY_CTRL][5]};
   endfunction

   function automatic logic [ADDR_W-1:0] index_port();
      return window_high() ? PORT_HIGH_KEY : PORT_LOW_INDEX;
   endfunction

   function automatic logic [ADDR_W-1:0] data_port();
      return window_high() ? PORT_HIGH_DATA : PORT_LOW_DATA;
   endfunction

   function automatic logic [IRQ_W-1:0] irq_number(input logic [3:0] slot);
      case (slot)
         4'd1:    return 4'd5;
         4'd2:    return 4'd2;
         4'd3:    return 4'd3;
         4'd4:    return 4'd4;
         4'd5:    return 4'd7;
         4'd6:    return 4'd6;
         4'd7:    return 4'd9;
         4'd8:    return 4'd10;
         default: return 4'd0;
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] serial_port_base(input logic [7:0] r,
                                                           input int fallback);
      int p;
      p = (int'(r & 8'hfe) << 2) & 'hff8;
      if (p < 'h100 || p > 'h3f8) p = fallback;
      return p[ADDR_W-1:0];
   endfunction

   // Data port write: stored only while unlocked and unprotected, then the fix-ups
   function automatic void store_data(input logic [7:0] val);
      logic [7:0] diff;
      if (!in_config || protect_set) return;
      diff = val ^ shadow_regs[index_reg];
      shadow_regs[index_reg] = val;
      if (index_reg == REG_STRAP_HI && diff[6]) begin
         protect_set = val[6];
      end else if (index_reg == REG_STRAP_LO && diff[1]) begin
         reload_resources(val[1]);
      end else if (index_reg == REG_COM_IRQ) begin
         // a nibble written to "none" snaps back to its default IRQ slot
         if (diff[3:0] != 4'd0 && shadow_regs[REG_COM_IRQ][3:0] == 4'd0)
            shadow_regs[REG_COM_IRQ][3:0] = 4'h3;
         if (diff[7:4] != 4'd0 && shadow_regs[REG_COM_IRQ][7:4] == 4'd0)
            shadow_regs[REG_COM_IRQ][7:4] = 4'h4;
      end
   endfunction

   // Apply one bus access to the shadow and return the result beat it must produce
   function automatic result_type decode_access(input bit wr, input logic [ADDR_W-1:0] addr,
                                                input logic [7:0] val);
      result_type outcome;
      bit hi, is_key, is_index, is_data, epp_ok, en;
      int p;
      hi       = window_high();
      is_key   = hi ? (addr == PORT_HIGH_KEY)  : (addr == PORT_LOW_KEY);
      is_index = hi ? (addr == PORT_HIGH_KEY)  : (addr == PORT_LOW_INDEX);
      is_data  = hi ? (addr == PORT_HIGH_DATA) : (addr == PORT_LOW_DATA);
      outcome  = '0;
      outcome.read_data = BYTE_IDLE;

      if (wr) begin
         if (!hi && is_key) begin
            in_config = (val == unlock_byte());
         end else if (!hi && is_index) begin
            index_reg = val;
         end else if (hi && is_key) begin
            if (val == unlock_byte() && !in_config) begin
               if (key_armed) begin
                  in_config = 1'b1;
                  key_armed = 1'b0;
               end else begin
                  key_armed = 1'b1;
               end
            end else if (in_config) begin
               index_reg = val;
               if (val == KEY_RELOCK) in_config = 1'b0;
            end else begin
               key_armed = 1'b0;
            end
         end else if (is_data) begin
            store_data(val);
         end
      end else if (in_config) begin
         if (is_index) begin
            outcome.read_data = index_reg;
         end else if (is_data) begin
            if (index_reg == REG_DRIVE_TYPE || index_reg >= REG_PROTECT_END || !protect_set)
               outcome.read_data = shadow_regs[index_reg];
         end
      end
      outcome.unlocked = in_config;

      p = 0;
      if (!shadow_regs[REG_FDC_CTRL][3] && shadow_regs[REG_FDC_BASE][7:6] != 2'd0) begin
         p = (int'(shadow_regs[REG_FDC_BASE] & 8'hfc) << 2) & 'hff0;
         if (p < 'h100 || p > 'h3f0) p = 'h3f0;
      end
      outcome.res.floppy_base = p[ADDR_W-1:0];
      outcome.res.floppy_irq  = irq_number(shadow_regs[REG_FDC_IRQ][7:4]);

      epp_ok = shadow_regs[REG_STRAP_HI][7] && shadow_regs[REG_LPT_MODE][2];
      p = 0;
      if (!shadow_regs[REG_DISABLE][7] && shadow_regs[REG_LPT_BASE][7:6] != 2'd0) begin
         p = int'(shadow_regs[REG_LPT_BASE]) << 2;
         p = p & (epp_ok ? 'h3f8 : 'h3fc);
         if (p < 'h100 || p > 'h3ff) p = 'h378;
      end
      outcome.res.printer_base = p[ADDR_W-1:0];
      outcome.res.printer_irq  = irq_number(shadow_regs[REG_LPT_IRQ][3:0]);
      outcome.res.printer_mode = {shadow_regs[REG_STRAP_HI][7] && shadow_regs[REG_LPT_MODE][3],
                                  epp_ok};

      en = !shadow_regs[REG_DISABLE][5] && shadow_regs[REG_COMA_BASE][7:6] != 2'd0;
      outcome.res.uart_a_base  = en ? serial_port_base(shadow_regs[REG_COMA_BASE], 'h3f8) : '0;
      outcome.res.uart_a_irq   = en ? irq_number(shadow_regs[REG_COM_IRQ][7:4]) : '0;
      outcome.res.uart_a_clock = shadow_regs[REG_COM_CLK][1] ? 2'd2 :
                                 (shadow_regs[REG_UART_CLK][1] ? 2'd1 : 2'd0);

      en = !shadow_regs[REG_DISABLE][4] && shadow_regs[REG_COMB_BASE][7:6] != 2'd0;
      outcome.res.uart_b_base  = en ? serial_port_base(shadow_regs[REG_COMB_BASE], 'h2f8) : '0;
      outcome.res.uart_b_irq   = en ? irq_number(shadow_regs[REG_COM_IRQ][3:0]) : '0;
      return outcome;
   endfunction

   // ---------------------------------------------------------------- pacing

   // Mostly back to back, often a short gap, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Stall the result side: hold tready low for a random gap, then raise it and pick the next gap
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------- drivers

   // Drive one access beat, wait for it to be taken, record what it must return.
   // Keep tvalid high across the edge when the next beat follows with no gap.
   task automatic send_access(input opcode_type op, input logic [ADDR_W-1:0] addr,
                              input logic [7:0] val);
      if (next_gap > 0) repeat (next_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-ADDR_W-BYTE_W){1'b0}}, val, addr};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(decode_access(op == OP_WRITE, addr, val));
      next_gap = pick_gap();
      req_held = (next_gap == 0);
      if (!req_held) req_tvalid <= 1'b0;
   endtask

   // Drop tvalid, let every expected beat come back, then give the block time to settle
   task automatic wait_idle();
      if (req_held) req_tvalid <= 1'b0;
      req_held = 1'b0;
      next_gap = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A strap write also restarts the whole configuration space
   task automatic write_strap(input logic [STRAP_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reset_shadow(value);
   endtask

   function automatic logic [7:0] maybe_break(input logic [7:0] key);
      return ($urandom_range(0, 11) == 0) ? 8'($urandom) : key;
   endfunction

   function automatic logic [7:0] pick_index();
      case ($urandom_range(0, 24))
         0:       return REG_LPT_MODE;
         1:       return REG_UART_CLK;
         2:       return REG_DISABLE;
         3:       return REG_FDC_CTRL;
         4:       return REG_DRIVE_TYPE;
         5:       return REG_STRAP_HI;
         6:       return REG_KEY_CTRL;
         7:       return REG_STRAP_LO;
         8:       return REG_PROTECT_END - 8'd1;
         9:       return REG_PROTECT_END;
         10:      return REG_COM_CLK;
         11:      return REG_FDC_BASE;
         12:      return REG_LPT_BASE;
         13:      return REG_COMA_BASE;
         14:      return REG_COMB_BASE;
         15:      return REG_LPT_IRQ;
         16:      return REG_COM_IRQ;
         17:      return REG_FDC_IRQ;
         default: return 8'($urandom);
      endcase
   endfunction

   // Unlock, run a burst of index/data traffic mixed with noise, maybe relock
   task automatic run_sessions(input int budget);
      int sent;
      int roll;
      logic [7:0] idx;
      logic [7:0] val;
      logic [ADDR_W-1:0] port;
      sent = 0;
      while (sent < budget) begin
         if (window_high()) begin
            send_access(OP_WRITE, PORT_HIGH_KEY, maybe_break(unlock_byte()));
            send_access(OP_WRITE, PORT_HIGH_KEY, maybe_break(unlock_byte()));
            sent += 2;
         end else begin
            send_access(OP_WRITE, PORT_LOW_KEY, maybe_break(unlock_byte()));
            sent += 1;
         end
         repeat ($urandom_range(2, 12)) begin
            roll = $urandom_range(0, 99);
            idx  = pick_index();
            val  = 8'($urandom);
            if (roll < 40) begin
               // set write protect only rarely, it freezes the space until the next strap
               if (idx == REG_STRAP_HI && $urandom_range(0, 39) != 0)
                  val[6] = shadow_regs[REG_STRAP_HI][6];
               send_access(OP_WRITE, index_port(), idx);
               send_access(OP_WRITE, data_port(), val);
               sent += 2;
            end else if (roll < 70) begin
               send_access(OP_WRITE, index_port(), idx);
               send_access(OP_READ, data_port(), val);
               sent += 2;
            end else if (roll < 80) begin
               send_access(OP_READ, index_port(), val);
               sent += 1;
            end else if (roll < 88) begin
               send_access(OP_READ, data_port(), val);
               sent += 1;
            end else begin
               // noise: either window's ports or any address at all
               case ($urandom_range(0, 9))
                  0:       port = PORT_LOW_KEY;
                  1:       port = PORT_LOW_INDEX;
                  2:       port = PORT_LOW_DATA;
                  3:       port = PORT_HIGH_KEY;
                  4:       port = PORT_HIGH_DATA;
                  default: port = 10'($urandom);
               endcase
               send_access(opcode_type'($urandom_range(0, 1)), port, val);
               sent += 1;
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            if (window_high()) send_access(OP_WRITE, PORT_HIGH_KEY, KEY_RELOCK);
            else send_access(OP_WRITE, PORT_LOW_KEY, 8'($urandom));
            sent += 1;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Low window after reset: lock rules, key bit from the key control register,
   // IRQ fix-up, group clear and reload, disables, EPP/ECP, sticky protect
   task automatic test_low_window();
      send_access(OP_READ,  10'h000,        8'h00);
      send_access(OP_READ,  10'h3ff,        8'hff);
      send_access(OP_WRITE, PORT_LOW_DATA,  8'h55);          // locked: dropped
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_DRIVE_TYPE); // index moves even when locked
      send_access(OP_READ,  PORT_LOW_DATA,  8'h00);
      send_access(OP_WRITE, PORT_LOW_KEY,   KEY_LOW);        // plain key misses the set low bit
      send_access(OP_WRITE, PORT_LOW_KEY,   unlock_byte());
      send_access(OP_READ,  PORT_LOW_INDEX, 8'h00);
      send_access(OP_READ,  PORT_LOW_DATA,  8'h00);
      send_access(OP_READ,  PORT_LOW_KEY,   8'h00);          // key port reads idle when open
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_COM_IRQ);
      send_access(OP_WRITE, PORT_LOW_DATA,  8'h00);          // both nibbles snap back
      send_access(OP_WRITE, PORT_LOW_DATA,  8'hf0);          // low nibble snaps back
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_STRAP_LO);
      send_access(OP_WRITE, PORT_LOW_DATA,  8'h00);          // clear the resource group
      send_access(OP_WRITE, PORT_LOW_DATA,  8'h02);          // reload it
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_DISABLE);
      send_access(OP_WRITE, PORT_LOW_DATA,  8'hb0);
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_LPT_MODE);
      send_access(OP_WRITE, PORT_LOW_DATA,  8'hff);
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_STRAP_HI);
      send_access(OP_WRITE, PORT_LOW_DATA,  8'hc0);          // EPP strap bit and protect on
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_UART_CLK);
      send_access(OP_READ,  PORT_LOW_DATA,  8'h00);          // protected low index
      send_access(OP_WRITE, PORT_LOW_INDEX, REG_DRIVE_TYPE);
      send_access(OP_READ,  PORT_LOW_DATA,  8'h00);          // drive types stay readable
      send_access(OP_WRITE, PORT_LOW_DATA,  8'h00);          // blocked by protect
      send_access(OP_WRITE, PORT_LOW_KEY,   8'h00);          // relock
   endtask

   // High window from an all-ones strap: double key, broken pair, relock byte
   task automatic test_high_window();
      write_strap(16'hffff);
      send_access(OP_READ,  PORT_LOW_DATA,  8'h00);          // old window now unmapped
      send_access(OP_READ,  PORT_HIGH_KEY,  8'h00);
      send_access(OP_WRITE, PORT_HIGH_KEY,  unlock_byte());
      send_access(OP_WRITE, PORT_HIGH_KEY,  8'h00);          // breaks the pair
      send_access(OP_WRITE, PORT_HIGH_KEY,  unlock_byte());
      send_access(OP_WRITE, PORT_HIGH_DATA, 8'h12);          // still locked, pair stays armed
      send_access(OP_WRITE, PORT_HIGH_KEY,  unlock_byte());
      send_access(OP_READ,  PORT_HIGH_KEY,  8'h00);
      send_access(OP_WRITE, PORT_HIGH_KEY,  REG_FDC_IRQ);
      send_access(OP_READ,  PORT_HIGH_DATA, 8'h00);
      send_access(OP_WRITE, PORT_HIGH_DATA, 8'h0f);
      send_access(OP_WRITE, PORT_HIGH_KEY,  REG_COM_CLK);
      send_access(OP_WRITE, PORT_HIGH_DATA, 8'h02);
      send_access(OP_WRITE, PORT_HIGH_KEY,  KEY_RELOCK);
      send_access(OP_READ,  PORT_HIGH_DATA, 8'h00);
   endtask

   // Random sessions under a sweep of straps, extremes first
   task automatic test_strap_sweep();
      logic [STRAP_W-1:0] straps [7];
      int i;
      straps = '{16'h0000, 16'hffff, 16'h8001, 16'h40fe,
                 16'($urandom), 16'($urandom), 16'($urandom)};
      for (i = 0; i < 7; i++) begin
         write_strap(straps[i]);
         run_sessions(180);
      end
   endtask

   // Full rate on both sides: no gaps, no stalls
   task automatic test_back_to_back();
      write_strap(16'($urandom));
      no_gaps = 1'b1;
      run_sessions(150);
      no_gaps = 1'b0;
   endtask

   // ---------------------------------------------------------------- checking

   // Compare each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result = result_type'(rsp_tdata[RESULT_W-1:0]);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result beat with nothing expected: %h", $time, rsp_tdata);
         end else begin
            want_result = pending_results.pop_front();
            if (seen_result.read_data        !== want_result.read_data        ||
                seen_result.unlocked         !== want_result.unlocked         ||
                seen_result.res.floppy_base  !== want_result.res.floppy_base  ||
                seen_result.res.floppy_irq   !== want_result.res.floppy_irq   ||
                seen_result.res.printer_base !== want_result.res.printer_base ||
                seen_result.res.printer_irq  !== want_result.res.printer_irq  ||
                seen_result.res.printer_mode !== want_result.res.printer_mode ||
                seen_result.res.uart_a_base  !== want_result.res.uart_a_base  ||
                seen_result.res.uart_a_irq   !== want_result.res.uart_a_irq   ||
                seen_result.res.uart_a_clock !== want_result.res.uart_a_clock ||
                seen_result.res.uart_b_base  !== want_result.res.uart_b_base  ||
                seen_result.res.uart_b_irq   !== want_result.res.uart_b_irq) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $write("%0t: mismatch (expected/actual) rd %h/%h cfg %b/%b ",
                         $time,
                         want_result.read_data, seen_result.read_data,
                         want_result.unlocked, seen_result.unlocked);
                  $write("fdc %h/%h irq %0d/%0d lpt %h/%h irq %0d/%0d mode %0d/%0d ",
                         want_result.res.floppy_base, seen_result.res.floppy_base,
                         want_result.res.floppy_irq, seen_result.res.floppy_irq,
                         want_result.res.printer_base, seen_result.res.printer_base,
                         want_result.res.printer_irq, seen_result.res.printer_irq,
                         want_result.res.printer_mode, seen_result.res.printer_mode);
                  $display("com1 %h/%h irq %0d/%0d clk %0d/%0d com2 %h/%h irq %0d/%0d",
                           want_result.res.uart_a_base, seen_result.res.uart_a_base,
                           want_result.res.uart_a_irq, seen_result.res.uart_a_irq,
                           want_result.res.uart_a_clock, seen_result.res.uart_a_clock,
                           want_result.res.uart_b_base, seen_result.res.uart_b_base,
                           want_result.res.uart_b_irq, seen_result.res.uart_b_irq);
               end
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("superio_config_port_decoder_top_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset_shadow('0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_low_window();
      test_high_window();
      test_strap_sweep();
      test_back_to_back();
      wait_idle();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("superio_config_port_decoder_top_tb: done, clean");
      else
         $display("superio_config_port_decoder_top_tb: done, errors");
      $finish;
   end

endmodule
